>>> rtl/tmcrd_pkg.sv
`default_nettype none
package tmcrd_pkg;

    // item kinds on the request channel
    localparam logic [1:0] KIND_BUS    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_PERIOD = 2'd2;

    // bus codes
    localparam logic [3:0] CODE_DIR_LAST   = 4'd7;
    localparam logic [3:0] CODE_SPEED_LAST = 4'd11;
    localparam logic [3:0] CODE_QUERY      = 4'd12;

    // result kinds
    localparam logic RESULT_DRIVE = 1'b0;
    localparam logic RESULT_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_MAX_DUTY = 1'b0;
    localparam logic CFG_MIN_DUTY = 1'b1;

    localparam logic [15:0] MAX_DUTY_RESET = 16'hFFFF;
    localparam logic [15:0] MIN_DUTY_RESET = 16'h0000;
    localparam logic [15:0] MID_DUTY       = 16'h7FFF;
    localparam logic [15:0] RAMP_STEP      = 16'd327;
    localparam logic [16:0] NEAR_BAND      = 17'd255;
    localparam logic [1:0]  DIVIDE_LAST    = 2'd2;
    localparam logic [6:0]  PERCENT        = 7'd100;
    localparam logic [13:0] PERCENT_CAP    = 14'd9999;

    // duty * 100 fits in 23 bits; the divider runs one quotient bit per cycle
    localparam int QUO_W = 23;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_STEPS_M1 = CNT_W'(QUO_W - 1);

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] bus_code;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic        motor_a_pin;
        logic [15:0] motor_a_compare;
        logic        motor_b_pin;
        logic [15:0] motor_b_compare;
        logic [13:0] speed_percent;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic       bus_we;
        logic [3:0] bus_code;
        logic       div_inc;
        logic       ramp_up;
        logic       ramp_down;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic       out_query;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic running;
        logic tick_below_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> rtl/tmcrd_ctrl.sv
`default_nettype none
module tmcrd_ctrl
    import tmcrd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_req  i_req,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DOWN,
        S_DIV,
        S_PUT
    } t_state;

    t_state     r_state, n_state;
    t_req       r_item;
    logic       r_query, n_query;

    assign o_stall = (r_state != S_IDLE);

    // decode the held request and sequence the datapath
    always_comb begin
        n_state = r_state;
        n_query = r_query;
        o_cmd   = '0;
        o_cmd.bus_code = r_item.bus_code;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_item.command)
                    KIND_BUS: begin
                        if (r_item.bus_code == CODE_QUERY) begin
                            o_cmd.div_start = 1'b1;
                            n_query = 1'b1;
                            n_state = S_DIV;
                        end else if (r_item.bus_code <= CODE_SPEED_LAST) begin
                            o_cmd.bus_we = 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        if (i_stat.running) begin
                            if (i_stat.tick_below_last) begin
                                o_cmd.div_inc = 1'b1;
                            end else begin
                                o_cmd.ramp_up = 1'b1;
                                n_state = S_DOWN;
                            end
                        end
                    end
                    KIND_PERIOD: begin
                        n_query = 1'b0;
                        n_state = S_PUT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DOWN: begin
                o_cmd.ramp_down = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_query = r_query;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_query <= 1'b0;
        end else begin
            r_state <= n_state;
            r_query <= n_query;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tmcrd_dp.sv
`default_nettype none
module tmcrd_dp
    import tmcrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_rsp             o_rsp
);

    logic [15:0]      r_max_duty, r_min_duty;
    logic [3:0]       r_dir;
    logic [1:0]       r_speed;
    logic             r_running;
    logic [1:0]       r_tick;
    logic [15:0]      r_duty;
    logic [15:0]      r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    t_rsp             r_out;
    logic             r_out_valid;

    logic [16:0]      rem_shift;
    logic             quo_bit;
    logic [15:0]      duty_up, duty_down, drive_d, fwd_cmp;
    logic [13:0]      pct;
    t_rsp             n_out;

    assign o_stat.running         = r_running;
    assign o_stat.tick_below_last = (r_tick < DIVIDE_LAST);
    assign o_stat.div_last        = (r_cnt == '0);
    assign o_stat.out_free        = !r_out_valid || !i_stall;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // ramp steps with saturation near the limits
    always_comb begin
        duty_up = r_duty;
        if (r_speed[0]) begin
            if ({1'b0, r_duty} + NEAR_BAND < {1'b0, r_max_duty}) begin
                duty_up = r_duty + RAMP_STEP;
            end else begin
                duty_up = r_max_duty;
            end
        end
        duty_down = r_duty;
        if (r_speed[1]) begin
            if ({1'b0, r_duty} > {1'b0, r_min_duty} + NEAR_BAND) begin
                duty_down = r_duty - RAMP_STEP;
            end else begin
                duty_down = r_min_duty;
            end
        end
    end

    // one restoring divide step
    assign rem_shift = {r_rem, r_quo[QUO_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, r_max_duty});

    // build the result
    always_comb begin
        drive_d = (r_duty > r_max_duty) ? MID_DUTY : r_duty;
        fwd_cmp = r_max_duty - drive_d;
        pct = (r_quo > QUO_W'(PERCENT_CAP)) ? PERCENT_CAP : r_quo[13:0];
        n_out = '0;
        if (i_cmd.out_query) begin
            n_out.result_kind   = RESULT_QUERY;
            n_out.speed_percent = pct;
        end else begin
            n_out.result_kind = RESULT_DRIVE;
            // left/right motor: right is forward and wins
            if (r_dir[3]) begin
                n_out.motor_a_pin     = 1'b1;
                n_out.motor_a_compare = fwd_cmp;
            end else if (r_dir[2]) begin
                n_out.motor_a_compare = drive_d;
            end
            // up/down motor: down is backward and wins
            if (r_dir[1]) begin
                n_out.motor_b_compare = drive_d;
            end else if (r_dir[0]) begin
                n_out.motor_b_pin     = 1'b1;
                n_out.motor_b_compare = fwd_cmp;
            end
        end
    end

    // control state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty  <= MAX_DUTY_RESET;
            r_min_duty  <= MIN_DUTY_RESET;
            r_dir       <= '0;
            r_speed     <= '0;
            r_running   <= 1'b0;
            r_tick      <= '0;
            r_duty      <= MID_DUTY;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_DUTY) begin
                    r_max_duty <= i_cfg_data;
                end else begin
                    r_min_duty <= i_cfg_data;
                end
            end
            // press or release a direction or speed bit
            if (i_cmd.bus_we) begin
                if (i_cmd.bus_code <= CODE_DIR_LAST) begin
                    r_dir[i_cmd.bus_code[2:1]] <= !i_cmd.bus_code[0];
                end else begin
                    r_speed[i_cmd.bus_code[1]] <= !i_cmd.bus_code[0];
                    r_running <= !i_cmd.bus_code[0];
                end
            end
            if (i_cmd.div_inc) begin
                r_tick <= r_tick + 2'd1;
            end
            if (i_cmd.ramp_up) begin
                r_duty <= duty_up;
            end
            if (i_cmd.ramp_down) begin
                r_duty <= duty_down;
                r_tick <= '0;
            end
            if (i_cmd.div_start) begin
                r_cnt <= DIV_STEPS_M1;
            end else if (i_cmd.div_step && r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= QUO_W'(r_duty) * QUO_W'(PERCENT);
        end else if (i_cmd.div_step) begin
            r_rem <= quo_bit ? 16'(rem_shift - {1'b0, r_max_duty}) : rem_shift[15:0];
            r_quo <= {r_quo[QUO_W-2:0], quo_bit};
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

>>> rtl/two_motor_command_ramp_drive.sv
// Channel    Direction  Handshake          Payload
// request    in         i_valid / o_stall  i_req (t_req: command, bus_code)
// result     out        o_valid / i_stall  o_rsp (t_rsp: drive update or speed reply)
// config     in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// Each request passes idle and an execute state; a ramping tick adds a ramp-down
// state, a period end a put state, and a speed query the serial divider and put state.
// The divider, one quotient bit per cycle, sets the query time.
// Reset is synchronous, active low; duty restarts at mid scale, limits at reset values.
// A full, stalled result register holds a finished result back; requests that
// give no result keep flowing.
`default_nettype none
module two_motor_command_ramp_drive
    import tmcrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_req        i_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    tmcrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tmcrd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

    // a result is only loaded into a free or draining output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a held result");

    // a ramp-up step is always followed by its ramp-down half
    a_ramp_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ramp_up |=> cmd.ramp_down)
        else $error("ramp step split");

    // the divider only runs while requests are held off
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> o_stall)
        else $error("divide step while accepting requests");

endmodule
`default_nettype wire

>>> tb/two_motor_command_ramp_drive_tb.sv
`default_nettype none
module two_motor_command_ramp_drive_tb;
    import tmcrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // item kind that the block drops
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // bus codes: start/end pairs, then the query and the unused tail
    localparam logic [3:0] CODE_UP_START    = 4'd0;
    localparam logic [3:0] CODE_UP_END      = 4'd1;
    localparam logic [3:0] CODE_DOWN_START  = 4'd2;
    localparam logic [3:0] CODE_DOWN_END    = 4'd3;
    localparam logic [3:0] CODE_LEFT_START  = 4'd4;
    localparam logic [3:0] CODE_LEFT_END    = 4'd5;
    localparam logic [3:0] CODE_RIGHT_START = 4'd6;
    localparam logic [3:0] CODE_RIGHT_END   = 4'd7;
    localparam logic [3:0] CODE_SPDUP_START = 4'd8;
    localparam logic [3:0] CODE_SPDUP_END   = 4'd9;
    localparam logic [3:0] CODE_SPDDN_START = 4'd10;
    localparam logic [3:0] CODE_SPDDN_END   = 4'd11;
    localparam logic [3:0] CODE_UNUSED_LO   = 4'd13;
    localparam logic [3:0] CODE_UNUSED_HI   = 4'd15;

    // cycles to let pass after the last result, longer than a speed query
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;

    typedef struct {
        t_req req;
        bit   pinned;
        t_rsp rsp;
    } t_step_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_req        i_req      = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = CFG_MAX_DUTY;
    logic [15:0] i_cfg_data = '0;

    // drive state mirror
    logic [15:0] duty_max;
    logic [15:0] duty_min;
    logic [3:0]  dir_held;
    logic [1:0]  speed_held;
    logic        ramp_on;
    logic [1:0]  tick_phase;
    logic [15:0] duty_now;

    t_rsp      motor_reports_due[$];
    t_step_row directed_rows[$];
    int        requests_taken    = 0;
    int        mismatches        = 0;
    int        phase_sent        = 0;
    int        long_hold_cycles  = 0;
    bit        no_gaps           = 1'b0;

    two_motor_command_ramp_drive DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    // direction pin and compare of one motor
    function automatic void motor_drive(input logic fwd, input logic back,
                                        input logic back_wins,
                                        output logic pin, output logic [15:0] cmp);
        logic [15:0] d;
        d = (duty_now > duty_max) ? MID_DUTY : duty_now;
        if (fwd && back) begin
            fwd = !back_wins;
        end
        if (fwd) begin
            pin = 1'b1;
            cmp = duty_max - d;
        end else if (back) begin
            pin = 1'b0;
            cmp = d;
        end else begin
            pin = 1'b0;
            cmp = '0;
        end
    endfunction

    // advance the mirror by one request; return 1 when it yields a result
    function automatic logic advance_drive_model(input t_req r, output t_rsp rsp);
        logic [3:0]  dir_bit;
        logic [1:0]  spd_bit;
        logic [31:0] pct;
        rsp = '0;
        if (r.command == KIND_BUS && r.bus_code == CODE_QUERY) begin
            // a zero maximum answers the cap
            if (duty_max == '0) begin
                pct = 32'(PERCENT_CAP);
            end else begin
                pct = (32'(duty_now) * 32'(PERCENT)) / 32'(duty_max);
            end
            if (pct > 32'(PERCENT_CAP)) begin
                pct = 32'(PERCENT_CAP);
            end
            rsp.result_kind   = RESULT_QUERY;
            rsp.speed_percent = pct[13:0];
            return 1'b1;
        end
        if (r.command == KIND_BUS) begin
            if (r.bus_code <= CODE_DIR_LAST) begin
                dir_bit = 4'b0001 << r.bus_code[2:1];
                dir_held = r.bus_code[0] ? (dir_held & ~dir_bit) : (dir_held | dir_bit);
            end else if (r.bus_code <= CODE_SPEED_LAST) begin
                spd_bit = 2'b01 << r.bus_code[1];
                speed_held = r.bus_code[0] ? (speed_held & ~spd_bit)
                                           : (speed_held | spd_bit);
                ramp_on = !r.bus_code[0];
            end
            return 1'b0;
        end
        if (r.command == KIND_TICK) begin
            // step the duty on every third running tick
            if (ramp_on) begin
                if (tick_phase < DIVIDE_LAST) begin
                    tick_phase = tick_phase + 2'd1;
                end else begin
                    if (speed_held[0]) begin
                        duty_now = (int'(duty_now) < int'(duty_max) - int'(NEAR_BAND))
                                   ? duty_now + RAMP_STEP : duty_max;
                    end
                    if (speed_held[1]) begin
                        duty_now = (int'(duty_now) > int'(duty_min) + int'(NEAR_BAND))
                                   ? duty_now - RAMP_STEP : duty_min;
                    end
                    tick_phase = '0;
                end
            end
            return 1'b0;
        end
        if (r.command == KIND_PERIOD) begin
            rsp.result_kind = RESULT_DRIVE;
            motor_drive(dir_held[3], dir_held[2], 1'b0,
                        rsp.motor_a_pin, rsp.motor_a_compare);
            motor_drive(dir_held[0], dir_held[1], 1'b1,
                        rsp.motor_b_pin, rsp.motor_b_compare);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_rsp drive_rsp(input logic a_pin, input logic [15:0] a_cmp,
                                       input logic b_pin, input logic [15:0] b_cmp);
        t_rsp r;
        r = '0;
        r.result_kind     = RESULT_DRIVE;
        r.motor_a_pin     = a_pin;
        r.motor_a_compare = a_cmp;
        r.motor_b_pin     = b_pin;
        r.motor_b_compare = b_cmp;
        return r;
    endfunction

    function automatic t_rsp query_rsp(input logic [13:0] pct);
        t_rsp r;
        r = '0;
        r.result_kind   = RESULT_QUERY;
        r.speed_percent = pct;
        return r;
    endfunction

    function automatic t_step_row make_row(input logic [1:0] kind, input logic [3:0] code,
                                           input bit pinned = 1'b0, input t_rsp rsp = '0);
        t_step_row s;
        s.req.command  = kind;
        s.req.bus_code = code;
        s.pinned       = pinned;
        s.rsp          = rsp;
        return s;
    endfunction

    // check results against the oldest due report, then mirror accepted requests
    always @(posedge i_clk) begin : channel_monitor
        t_rsp want;
        t_rsp due;
        logic yields;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (motor_reports_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with none due", o_rsp));
                end else begin
                    want = motor_reports_due.pop_front();
                    check_field("result_kind", 16'(o_rsp.result_kind),
                                16'(want.result_kind));
                    check_field("motor_a_pin", 16'(o_rsp.motor_a_pin),
                                16'(want.motor_a_pin));
                    check_field("motor_a_compare", o_rsp.motor_a_compare,
                                want.motor_a_compare);
                    check_field("motor_b_pin", 16'(o_rsp.motor_b_pin),
                                16'(want.motor_b_pin));
                    check_field("motor_b_compare", o_rsp.motor_b_compare,
                                want.motor_b_compare);
                    check_field("speed_percent", 16'(o_rsp.speed_percent),
                                16'(want.speed_percent));
                end
            end
            if (i_valid && !o_stall) begin
                yields = advance_drive_model(i_req, due);
                if (requests_taken < directed_rows.size()
                    && directed_rows[requests_taken].pinned) begin
                    due = directed_rows[requests_taken].rsp;
                end
                if (yields) begin
                    motor_reports_due.push_back(due);
                end
                requests_taken++;
            end
        end
    end

    // result side: random stall before each result, one long hold on request
    initial begin : result_sink
        int hold;
        forever begin
            if (long_hold_cycles > 0) begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end else begin
                hold = no_gaps ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input t_req r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!(r.command == KIND_UNUSED
              || (r.command == KIND_BUS && r.bus_code >= CODE_UNUSED_LO))) begin
            phase_sent++;
        end
    endtask

    // drop valid and wait until the block has nothing left in flight
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (motor_reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_MAX_DUTY) begin
            duty_max = data;
        end else begin
            duty_min = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // request inside a ramp burst: mostly ticks
    function automatic t_req burst_request();
        t_req r;
        int   roll;
        roll = $urandom_range(0, 99);
        r.bus_code = 4'($urandom_range(0, 15));
        if (roll < 60) begin
            r.command = KIND_TICK;
        end else if (roll < 80) begin
            r.command = KIND_PERIOD;
        end else if (roll < 85) begin
            r.command  = KIND_BUS;
            r.bus_code = CODE_QUERY;
        end else begin
            r.command  = KIND_BUS;
            r.bus_code = 4'($urandom_range(CODE_UP_START, CODE_DIR_LAST));
        end
        return r;
    endfunction

    // one setting of the limits, then ramp bursts mixed with raw noise
    task automatic run_phase(input logic [15:0] max_val, input logic [15:0] min_val,
                             input int n_items, input int max_body);
        t_req r;
        bit   go_up;
        int   body;
        settle_block();
        write_register(CFG_MAX_DUTY, max_val);
        write_register(CFG_MIN_DUTY, min_val);
        phase_sent = 0;
        while (phase_sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                go_up = 1'($urandom_range(0, 1));
                r.command = KIND_BUS;
                if ($urandom_range(0, 1)) begin
                    r.bus_code = go_up ? CODE_SPDDN_END : CODE_SPDUP_END;
                    send_request(r);
                end
                r.bus_code = go_up ? CODE_SPDUP_START : CODE_SPDDN_START;
                send_request(r);
                body = $urandom_range(0, max_body);
                repeat (body) send_request(burst_request());
                // leave some bursts open
                if ($urandom_range(0, 9) != 0) begin
                    r.command  = KIND_BUS;
                    r.bus_code = go_up ? CODE_SPDUP_END : CODE_SPDDN_END;
                    send_request(r);
                end
            end else begin
                r.command  = 2'($urandom_range(0, 3));
                r.bus_code = 4'($urandom_range(0, 15));
                send_request(r);
            end
        end
    endtask

    initial begin : stimulus
        duty_max   = MAX_DUTY_RESET;
        duty_min   = MIN_DUTY_RESET;
        dir_held   = '0;
        speed_held = '0;
        ramp_on    = 1'b0;
        tick_phase = '0;
        duty_now   = MID_DUTY;

        // directed walk from reset
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START, 1'b1,
                                         drive_rsp(1'b0, 16'd0, 1'b0, 16'd0)));
        directed_rows.push_back(make_row(KIND_BUS, CODE_QUERY, 1'b1, query_rsp(14'd49)));
        directed_rows.push_back(make_row(KIND_BUS, CODE_UP_START));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START, 1'b1,
                                         drive_rsp(1'b0, 16'd0, 1'b1, 16'd32768)));
        // up and down held: down wins
        directed_rows.push_back(make_row(KIND_BUS, CODE_DOWN_START));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START, 1'b1,
                                         drive_rsp(1'b0, 16'd0, 1'b0, 16'd32767)));
        directed_rows.push_back(make_row(KIND_BUS, CODE_LEFT_START));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START, 1'b1,
                                         drive_rsp(1'b0, 16'd32767, 1'b0, 16'd32767)));
        // left and right held: right wins
        directed_rows.push_back(make_row(KIND_BUS, CODE_RIGHT_START));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START, 1'b1,
                                         drive_rsp(1'b1, 16'd32768, 1'b0, 16'd32767)));
        directed_rows.push_back(make_row(KIND_BUS, CODE_UP_END));
        directed_rows.push_back(make_row(KIND_BUS, CODE_DOWN_END));
        directed_rows.push_back(make_row(KIND_BUS, CODE_LEFT_END));
        // tick while the ramp is stopped
        directed_rows.push_back(make_row(KIND_TICK, CODE_UNUSED_HI));
        directed_rows.push_back(make_row(KIND_BUS, CODE_SPDUP_START));
        repeat (3) directed_rows.push_back(make_row(KIND_TICK, CODE_UP_START));
        directed_rows.push_back(make_row(KIND_BUS, CODE_QUERY));
        directed_rows.push_back(make_row(KIND_BUS, CODE_SPDUP_END));
        directed_rows.push_back(make_row(KIND_BUS, CODE_SPDDN_START));
        directed_rows.push_back(make_row(KIND_TICK, CODE_UP_START));
        directed_rows.push_back(make_row(KIND_BUS, CODE_SPDDN_END));
        // unused code and unused kind
        directed_rows.push_back(make_row(KIND_BUS, CODE_UNUSED_HI));
        directed_rows.push_back(make_row(KIND_UNUSED, CODE_QUERY));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UNUSED_HI));
        directed_rows.push_back(make_row(KIND_BUS, CODE_RIGHT_END));
        directed_rows.push_back(make_row(KIND_PERIOD, CODE_UP_START));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req);
        end

        // limits at the extremes, then random limits
        run_phase(16'd65535, 16'd0, 250, 30);
        run_phase(16'd256, 16'd0, 200, 30);
        run_phase(16'd256, 16'd65279, 150, 20);
        run_phase(16'd65535, 16'd65279, 200, 20);
        // arm the long hold only once nothing is in flight
        settle_block();
        long_hold_cycles = LONG_HOLD;
        run_phase(16'd65535, 16'd0, 350, 300);
        no_gaps = 1'b1;
        run_phase(16'd40000, 16'd20000, 200, 60);
        no_gaps = 1'b0;
        repeat (2) begin
            run_phase(16'($urandom_range(256, 65535)), 16'($urandom_range(0, 65279)),
                      200, 60);
        end

        settle_block();
        if (mismatches == 0) begin
            $display("two_motor_command_ramp_drive regression: pass");
        end else begin
            $display("two_motor_command_ramp_drive regression: fail");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #4_000_000;
        $display("two_motor_command_ramp_drive regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
